// File: hw/rtl/cltw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cltw_pkg: shared types and constants for the character LCD text writer
// Item formats, op codes, register indexes, cursor address helpers.
// ----------------------------------------------------------------------------
package cltw_pkg;

  typedef enum logic [1:0] {
    OP_TEXT  = 2'd0,
    OP_PLACE = 2'd1,
    OP_RAW   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_COUNT = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } reg_idx_t;

  localparam logic [7:0] ADDR_CMD   = 8'h80;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [6:0] ADDR_MASK  = 7'h7F;

  localparam logic [2:0] LINE_COUNT_RST = 3'd2;
  localparam logic [5:0] LINE_WIDTH_RST = 6'd16;

  localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
    logic [5:0] col;
    logic [1:0] row;
    logic       raw_select;
  } in_item_t;

  typedef struct packed {
    logic       rs_level;
    logic [3:0] nibble;
    logic       last;
  } out_item_t;

  // one or two bytes to send for one accepted item
  typedef struct packed {
    logic       two;
    logic       rs0;
    logic [7:0] b0;
    logic       rs1;
    logic [7:0] b1;
  } cmd_t;

  typedef struct packed {
    logic [2:0] line_count;
    logic [5:0] line_width;
  } cfg_t;

  // fold a row at or past the used count back to the top
  function automatic logic [1:0] clamp_row(input logic [2:0] r, input logic [2:0] lc);
    clamp_row = ((r >= lc) || (r > 3'd3)) ? 2'd0 : r[1:0];
  endfunction

  function automatic logic [7:0] cursor_addr(input logic [5:0] c, input logic [1:0] r);
    logic [6:0] sum;
    sum = ({1'b0, c} + ROW_BASE[r]) & ADDR_MASK;
    cursor_addr = ADDR_CMD | {1'b0, sum};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cltw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cltw_front: item intake and cursor tracking
// Holds configuration and cursor, turns each item into one or two bytes (none for the unused op).
// ----------------------------------------------------------------------------
module cltw_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [cltw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cltw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire cltw_pkg::in_item_t in_item,
  input  wire logic               q_full,
  output logic                    q_push,
  output cltw_pkg::cmd_t          q_wdata
);
  import cltw_pkg::*;

  cfg_t       cfg_r;
  logic [5:0] col_r, col_nxt;
  logic [1:0] row_r, row_nxt;
  logic       accept;
  logic       emits;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign q_push    = accept && emits;

  always_comb begin
    logic [5:0] c;
    logic [1:0] r;
    logic       wrap;
    logic [7:0] wrap_addr;
    logic       rs_s;
    logic [7:0] b_s;
    c         = col_r;
    r         = row_r;
    wrap      = 1'b0;
    wrap_addr = 8'h00;
    rs_s      = 1'b0;
    b_s       = 8'h00;
    emits     = 1'b1;
    q_wdata   = '0;
    case (op_t'(in_item.op))
      OP_TEXT: begin
        if (c >= cfg_r.line_width) begin
          wrap      = 1'b1;
          r         = clamp_row({1'b0, r} + 3'd1, cfg_r.line_count);
          c         = 6'd0;
          wrap_addr = cursor_addr(c, r);
        end
        if (in_item.byte_value == CH_NEWLINE) begin
          r   = clamp_row({1'b0, r} + 3'd1, cfg_r.line_count);
          b_s = cursor_addr(c, r);
        end else if (in_item.byte_value == CH_RETURN) begin
          c   = 6'd0;
          r   = clamp_row({1'b0, r}, cfg_r.line_count);
          b_s = cursor_addr(c, r);
        end else begin
          rs_s = 1'b1;
          b_s  = in_item.byte_value;
          c    = c + 6'd1;
        end
        if (wrap) begin
          q_wdata = '{two: 1'b1, rs0: 1'b0, b0: wrap_addr, rs1: rs_s, b1: b_s};
        end else begin
          q_wdata = '{two: 1'b0, rs0: rs_s, b0: b_s, rs1: 1'b0, b1: 8'h00};
        end
      end
      OP_PLACE: begin
        c       = in_item.col;
        r       = clamp_row({1'b0, in_item.row}, cfg_r.line_count);
        q_wdata = '{two: 1'b0, rs0: 1'b0, b0: cursor_addr(c, r), rs1: 1'b0, b1: 8'h00};
      end
      OP_RAW: begin
        q_wdata = '{two: 1'b0, rs0: in_item.raw_select, b0: in_item.byte_value,
                    rs1: 1'b0, b1: 8'h00};
      end
      default: begin
        emits = 1'b0;
      end
    endcase
    col_nxt = accept ? c : col_r;
    row_nxt = accept ? r : row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{line_count: LINE_COUNT_RST, line_width: LINE_WIDTH_RST};
      col_r <= 6'd0;
      row_r <= 2'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_LINE_COUNT: cfg_r.line_count <= cfg_data[2:0];
          REG_LINE_WIDTH: cfg_r.line_width <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cltw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cltw_queue: byte command queue
// Small register queue that decouples intake from the nibble serializer.
// ----------------------------------------------------------------------------
module cltw_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cltw_pkg::cmd_t wdata,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output cltw_pkg::cmd_t      rdata
);
  import cltw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/cltw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cltw_back: nibble serializer
// Splits each queued command into nibbles, high first, into an output register.
// ----------------------------------------------------------------------------
module cltw_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire cltw_pkg::cmd_t q_rdata,
  output logic                q_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output cltw_pkg::out_item_t out_item
);
  import cltw_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       is_last;
  logic [7:0] cur_byte;
  logic       cur_rs;

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  // output register takes a new nibble when empty or being drained
  assign load     = !q_empty && (!out_valid_r || out_pop);
  assign cur_byte = idx_r[1] ? q_rdata.b1 : q_rdata.b0;
  assign cur_rs   = idx_r[1] ? q_rdata.rs1 : q_rdata.rs0;
  assign is_last  = (idx_r == (q_rdata.two ? 2'd3 : 2'd1));
  assign q_pop    = load && is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt = '{rs_level: cur_rs,
                  nibble:   idx_r[0] ? cur_byte[3:0] : cur_byte[7:4],
                  last:     is_last};
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/char_lcd_text_writer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_text_writer_top: character LCD text writer, 4-bit bus
// Turns text, cursor placement and raw byte items into tagged nibble writes.
//
//   channel  handshake            payload
//   in_      in_push / in_full    in_item   (op, byte_value, col, row, raw_select)
//   out_     out_empty / out_pop  out_item  (rs_level, nibble, last)
//   cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The serializer sends one nibble per cycle unless out_pop stalls; an item gives
// two nibbles, or four for a two-byte item (none for the unused op).
// Intake and cursor update are registered and run ahead by QUEUE_DEPTH items.
// Synchronous reset clears cursor, queue and output valid; registers reload
// their reset values. A stalled out_pop holds the nibble and fills the queue.
// ----------------------------------------------------------------------------
module char_lcd_text_writer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [cltw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cltw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire cltw_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output cltw_pkg::out_item_t      out_item
);
  import cltw_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_wdata, q_rdata;

  cltw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  cltw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  cltw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
